>>> src/kpd_pkg.sv
// Shared types, codes and constants of the keypad selection decoder.
`default_nettype none

package kpd_pkg;

  // Event kinds carried in cmd
  localparam logic [1:0] EV_TICK    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_PLAY = 3'd1;
  localparam logic [2:0] ACT_STOP = 3'd2;
  localparam logic [2:0] ACT_VUP  = 3'd3;
  localparam logic [2:0] ACT_VDN  = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] IDX_TIMEOUT = 8'd0;
  localparam logic [7:0] IDX_STOP    = 8'd1;
  localparam logic [7:0] IDX_VUP     = 8'd2;
  localparam logic [7:0] IDX_VDN     = 8'd3;

  // Configuration reset values
  localparam logic [3:0] RST_TIMEOUT = 4'd5;
  localparam logic [7:0] RST_STOP    = 8'd48;
  localparam logic [7:0] RST_VUP     = 8'd49;
  localparam logic [7:0] RST_VDN     = 8'd50;

  // Character ranges
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Decoder mode, encoded as on mode_now
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_LETTER  = 3'd1,
    MODE_LET_REL = 3'd2,
    MODE_DIGIT   = 3'd3,
    MODE_STOP    = 3'd4,
    MODE_VUP     = 3'd5,
    MODE_VDN     = 3'd6
  } mode_t;

  typedef struct packed {
    logic [3:0] timeout;
    logic [7:0] stop_code;
    logic [7:0] vup_code;
    logic [7:0] vdn_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] song_letter;
    logic [7:0] song_digit;
    logic [2:0] mode_now;
  } res_t;

endpackage

`default_nettype wire

>>> src/kpd_if.sv
// Valid/ready channel interfaces for key events, results and config writes.
`default_nettype none

interface kpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] key_code;
  modport source (output valid, cmd, key_code, input ready);
  modport sink   (input valid, cmd, key_code, output ready);
endinterface

interface kpd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] song_letter;
  logic [7:0] song_digit;
  logic [2:0] mode_now;
  modport source (output valid, action, song_letter, song_digit, mode_now, input ready);
  modport sink   (input valid, action, song_letter, song_digit, mode_now, output ready);
endinterface

interface kpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/kpd_cfg.sv
// Configuration register file of the keypad selection decoder.
`default_nettype none

module kpd_cfg
  import kpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_index,
  input  wire logic [7:0] wr_data,
  output cfg_t            cfg
);

  cfg_t cfg_r;

  // Write one register per beat; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout   <= RST_TIMEOUT;
      cfg_r.stop_code <= RST_STOP;
      cfg_r.vup_code  <= RST_VUP;
      cfg_r.vdn_code  <= RST_VDN;
    end else if (wr_en) begin
      case (wr_index)
        IDX_TIMEOUT: cfg_r.timeout   <= wr_data[3:0];
        IDX_STOP:    cfg_r.stop_code <= wr_data;
        IDX_VUP:     cfg_r.vup_code  <= wr_data;
        IDX_VDN:     cfg_r.vdn_code  <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/kpd_core.sv
// Mode state machine: decodes one key event per cycle, on cycles with fire high, into a result.
`default_nettype none

module kpd_core
  import kpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] key_code,
  input  cfg_t            cfg,
  output res_t            res
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] letter_r, letter_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] cnt_inc;
  logic       is_letter, is_digit, is_press, is_rel, is_tick;

  assign is_letter = key_code inside {[CH_A:CH_Z]};
  assign is_digit  = key_code inside {[CH_ZERO:CH_NINE]};
  assign is_tick   = (cmd == EV_TICK);
  assign is_press  = (cmd == EV_PRESS);
  assign is_rel    = (cmd == EV_RELEASE);
  assign cnt_inc   = cnt_r + 4'd1;

  // Next state
  always_comb begin
    mode_nxt   = mode_r;
    letter_nxt = letter_r;
    digit_nxt  = digit_r;
    cnt_nxt    = cnt_r;
    case (mode_r)
      MODE_LETTER: begin
        if (is_rel && key_code == letter_r) mode_nxt = MODE_LET_REL;
      end
      MODE_LET_REL: begin
        if (is_tick) begin
          // counter wraps mod 16; cleared only on timeout
          if (cnt_inc == cfg.timeout) begin
            cnt_nxt  = 4'd0;
            mode_nxt = MODE_IDLE;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else if (is_press && is_digit) begin
          digit_nxt = key_code;
          mode_nxt  = MODE_DIGIT;
        end else if (is_press && is_letter) begin
          letter_nxt = key_code;
          mode_nxt   = MODE_LETTER;
        end
      end
      MODE_DIGIT: begin
        if (is_rel && key_code == digit_r) mode_nxt = MODE_IDLE;
      end
      MODE_STOP: begin
        if (is_tick || (is_rel && key_code == cfg.stop_code)) mode_nxt = MODE_IDLE;
      end
      MODE_VUP: begin
        if (is_tick || (is_rel && key_code == cfg.vup_code)) mode_nxt = MODE_IDLE;
      end
      MODE_VDN: begin
        if (is_tick || (is_rel && key_code == cfg.vdn_code)) mode_nxt = MODE_IDLE;
      end
      default: begin
        // idle: letter test first, then special keys in order
        if (is_press) begin
          if (is_letter) begin
            letter_nxt = key_code;
            mode_nxt   = MODE_LETTER;
          end else if (key_code == cfg.stop_code) begin
            mode_nxt = MODE_STOP;
          end else if (key_code == cfg.vup_code) begin
            mode_nxt = MODE_VUP;
          end else if (key_code == cfg.vdn_code) begin
            mode_nxt = MODE_VDN;
          end
        end
      end
    endcase
  end

  // Result of this event
  always_comb begin
    res.action      = ACT_NONE;
    res.song_letter = 8'd0;
    res.song_digit  = 8'd0;
    res.mode_now    = mode_nxt;
    case (mode_r)
      MODE_DIGIT: begin
        if (is_rel && key_code == digit_r) begin
          res.action      = ACT_PLAY;
          res.song_letter = letter_r;
          res.song_digit  = digit_r;
        end
      end
      MODE_STOP: if (is_tick) res.action = ACT_STOP;
      MODE_VUP:  if (is_tick) res.action = ACT_VUP;
      MODE_VDN:  if (is_tick) res.action = ACT_VDN;
      default: ;
    endcase
  end

  // State registers; cmd 3 falls through every arm above and changes nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      letter_r <= 8'd0;
      digit_r  <= 8'd0;
      cnt_r    <= 4'd0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      letter_r <= letter_nxt;
      digit_r  <= digit_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/keypad_selection_decoder.sv
// Keypad selection decoder: input register, mode decoder, result register.
// An event beat is held in the input register, decoded, and its result written
// to the result register, where it is shown until taken downstream.
// Throughput: one event per cycle while the result register is not stalled.
// Reset (rst_n low, synchronous): both stages empty, mode idle, held letter,
// digit and tick count zero, config registers back to their defaults.
`default_nettype none

module keypad_selection_decoder
  import kpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  kpd_in_if.sink     in_ch,
  kpd_out_if.source  out_ch,
  kpd_cfg_if.sink    cfg_ch
);

  logic       in_valid_r;
  logic [1:0] in_cmd_r;
  logic [7:0] in_key_r;
  logic       out_valid_r;
  res_t       out_r;
  res_t       res;
  cfg_t       cfg;
  logic       advance;

  // Output stage frees when empty or being taken
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  kpd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  kpd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_valid_r && advance),
    .cmd      (in_cmd_r),
    .key_code (in_key_r),
    .cfg      (cfg),
    .res      (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_cmd_r <= in_ch.cmd;
      in_key_r <= in_ch.key_code;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = out_r.action;
  assign out_ch.song_letter = out_r.song_letter;
  assign out_ch.song_digit  = out_r.song_digit;
  assign out_ch.mode_now    = out_r.mode_now;

endmodule

`default_nettype wire

>>> src/kpd_checker.sv
// Port-level checks for the keypad selection decoder, bound to the top level.
`default_nettype none

module kpd_checker
  import kpd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] action,
  input wire logic [7:0] song_letter,
  input wire logic [7:0] song_digit,
  input wire logic [2:0] mode_now
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(song_letter)
      && $stable(song_digit) && $stable(mode_now))
    else $error("result beat changed while stalled");

  // Any command returns the decoder to idle
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && action != ACT_NONE |-> mode_now == MODE_IDLE)
    else $error("command issued without returning to idle");

  // Song fields are zero unless a song is played
  a_song_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && action != ACT_PLAY |-> song_letter == 8'd0 && song_digit == 8'd0)
    else $error("song fields set without play");

  // A played song carries a letter and a digit
  a_song_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && action == ACT_PLAY |-> song_letter >= CH_A && song_letter <= CH_Z
      && song_digit >= CH_ZERO && song_digit <= CH_NINE)
    else $error("play with malformed selection");

endmodule

bind keypad_selection_decoder kpd_checker u_kpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .action      (out_ch.action),
  .song_letter (out_ch.song_letter),
  .song_digit  (out_ch.song_digit),
  .mode_now    (out_ch.mode_now)
);

`default_nettype wire

>>> test/keypad_selection_decoder_test.sv
// Self-checking regression for the keypad selection decoder: random and directed key beats.
`default_nettype none

module keypad_selection_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kpd_pkg::*;

  localparam logic [1:0] EV_UNKNOWN  = 2'd3;
  localparam int         PHASE_ITEMS = 125;
  localparam int         PHASE_COUNT = 8;

  // Tracks the decoder's mode, held keys and tick count, and queues the result
  // each key beat must produce.
  class selection_scoreboard;
    logic [3:0]  timeout_ticks;
    logic [7:0]  stop_code;
    logic [7:0]  vup_code;
    logic [7:0]  vdn_code;
    mode_t       mode;
    logic [7:0]  letter;
    logic [7:0]  digit;
    logic [3:0]  tick_count;
    res_t        results_due[$];
    int unsigned errors;

    function new();
      reset();
      errors = 0;
    endfunction

    function void reset();
      timeout_ticks = RST_TIMEOUT;
      stop_code     = RST_STOP;
      vup_code      = RST_VUP;
      vdn_code      = RST_VDN;
      mode          = MODE_IDLE;
      letter        = '0;
      digit         = '0;
      tick_count    = '0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] value);
      case (idx)
        IDX_TIMEOUT: timeout_ticks = value[3:0];
        IDX_STOP:    stop_code = value;
        IDX_VUP:     vup_code = value;
        IDX_VDN:     vdn_code = value;
        default:     ;
      endcase
    endfunction

    function bit is_letter(logic [7:0] k);
      return k >= CH_A && k <= CH_Z;
    endfunction

    function bit is_digit(logic [7:0] k);
      return k >= CH_ZERO && k <= CH_NINE;
    endfunction

    // armed special key: fires on a tick, dropped on release of its own key
    function logic [2:0] armed_key(logic [1:0] cmd, logic [7:0] key, logic [7:0] code,
                                   logic [2:0] act);
      if (cmd == EV_TICK) begin
        mode = MODE_IDLE;
        return act;
      end
      if (cmd == EV_RELEASE && key == code) mode = MODE_IDLE;
      return ACT_NONE;
    endfunction

    function res_t decode_event(logic [1:0] cmd, logic [7:0] key);
      res_t r;
      r = '0;
      if (cmd != EV_UNKNOWN) begin
        case (mode)
          MODE_LETTER: begin
            if (cmd == EV_RELEASE && key == letter) mode = MODE_LET_REL;
          end
          MODE_LET_REL: begin
            // tick count wraps mod 16 and is only cleared on a timeout
            if (cmd == EV_TICK) begin
              tick_count = tick_count + 4'd1;
              if (tick_count == timeout_ticks) begin
                tick_count = '0;
                mode = MODE_IDLE;
              end
            end else if (cmd == EV_PRESS && is_digit(key)) begin
              digit = key;
              mode = MODE_DIGIT;
            end else if (cmd == EV_PRESS && is_letter(key)) begin
              letter = key;
              mode = MODE_LETTER;
            end
          end
          MODE_DIGIT: begin
            if (cmd == EV_RELEASE && key == digit) begin
              r.action = ACT_PLAY;
              r.song_letter = letter;
              r.song_digit = digit;
              mode = MODE_IDLE;
            end
          end
          MODE_STOP: r.action = armed_key(cmd, key, stop_code, ACT_STOP);
          MODE_VUP:  r.action = armed_key(cmd, key, vup_code, ACT_VUP);
          MODE_VDN:  r.action = armed_key(cmd, key, vdn_code, ACT_VDN);
          default: begin
            // letters win over the special codes, then stop, vol up, vol down
            if (cmd == EV_PRESS) begin
              if (is_letter(key)) begin
                letter = key;
                mode = MODE_LETTER;
              end else if (key == stop_code) begin
                mode = MODE_STOP;
              end else if (key == vup_code) begin
                mode = MODE_VUP;
              end else if (key == vdn_code) begin
                mode = MODE_VDN;
              end
            end
          end
        endcase
      end
      r.mode_now = mode;
      return r;
    endfunction

    // queues the result of an accepted key beat; 1 when the beat had any effect
    function bit note_event(logic [1:0] cmd, logic [7:0] key);
      mode_t      m0;
      logic [3:0] t0;
      logic [7:0] l0;
      logic [7:0] d0;
      res_t       r;
      m0 = mode;
      t0 = tick_count;
      l0 = letter;
      d0 = digit;
      r = decode_event(cmd, key);
      results_due.push_back(r);
      return r.action != ACT_NONE || mode != m0 || tick_count != t0 ||
             letter != l0 || digit != d0;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        $error("result beat with nothing pending: action %0d, mode_now %0d",
               got.action, got.mode_now);
        errors++;
        return;
      end
      want = results_due.pop_front();
      check_field("action", want.action, got.action);
      check_field("song_letter", want.song_letter, got.song_letter);
      check_field("song_digit", want.song_digit, got.song_digit);
      check_field("mode_now", want.mode_now, got.mode_now);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  kpd_in_if  in_ch();
  kpd_out_if out_ch();
  kpd_cfg_if cfg_ch();

  keypad_selection_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  selection_scoreboard sb = new();
  bit          steady_source;
  int unsigned counted;

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CH_A + 8'($urandom_range(0, 25));
      4, 5:       return CH_ZERO + 8'($urandom_range(0, 9));
      6:          return sb.stop_code;
      7:          return $urandom_range(0, 1) ? sb.vup_code : sb.vdn_code;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return CH_A + 8'($urandom_range(0, 25));
      1:       return CH_ZERO + 8'($urandom_range(0, 9));
      2:       return 8'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
    endcase
  endfunction

  // Result sink: ready runs broken by random stalls
  initial begin
    int unsigned run_len;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(res_t'({out_ch.action, out_ch.song_letter, out_ch.song_digit,
                              out_ch.mode_now}));
    end
  end

  task automatic send_event(logic [1:0] cmd, logic [7:0] key);
    int unsigned gap;
    gap = steady_source ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.key_code <= key;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.note_event(cmd, key)) counted++;
  endtask

  // leaves valid high; the caller lowers it after the last write
  task automatic write_reg(logic [7:0] idx, logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(logic [7:0] timeout, logic [7:0] stop, logic [7:0] vup,
                           logic [7:0] vdn);
    write_reg(IDX_TIMEOUT, timeout);
    write_reg(IDX_STOP, stop);
    write_reg(IDX_VUP, vup);
    write_reg(IDX_VDN, vdn);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
  endtask

  // letter, release, some ticks, digit, release; with occasional stray keys
  task automatic play_sequence();
    logic [7:0]  let_key;
    logic [7:0]  dig_key;
    int unsigned ticks;
    let_key = CH_A + 8'($urandom_range(0, 25));
    dig_key = CH_ZERO + 8'($urandom_range(0, 9));
    send_event(EV_PRESS, let_key);
    if ($urandom_range(0, 9) == 0) send_event(2'($urandom_range(0, 3)), pick_key());
    send_event(EV_RELEASE, ($urandom_range(0, 9) == 0) ? pick_key() : let_key);
    ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
    repeat (ticks) send_event(EV_TICK, 8'($urandom_range(0, 255)));
    send_event(EV_PRESS, ($urandom_range(0, 9) == 0) ? pick_key() : dig_key);
    send_event(EV_RELEASE, ($urandom_range(0, 9) == 0) ? pick_key() : dig_key);
  endtask

  // special key: held to the next tick, released early, or disturbed
  task automatic special_sequence();
    logic [7:0] code;
    case ($urandom_range(0, 2))
      0:       code = sb.stop_code;
      1:       code = sb.vup_code;
      default: code = sb.vdn_code;
    endcase
    send_event(EV_PRESS, code);
    case ($urandom_range(0, 3))
      0: send_event(EV_RELEASE, code);
      1: begin
        send_event(2'($urandom_range(1, 2)), pick_key());
        send_event(EV_TICK, 8'($urandom_range(0, 255)));
      end
      default: send_event(EV_TICK, 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic run_phase(int unsigned items);
    counted = 0;
    steady_source = ($urandom_range(0, 3) == 0);
    while (counted < items) begin
      // release a held key most of the time so sequences start from idle
      if ($urandom_range(0, 4) != 0) begin
        if (sb.mode == MODE_LETTER) send_event(EV_RELEASE, sb.letter);
        else if (sb.mode == MODE_DIGIT) send_event(EV_RELEASE, sb.digit);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: play_sequence();
        9, 10, 11, 12, 13:         special_sequence();
        default:                   send_event(2'($urandom_range(0, 3)), pick_key());
      endcase
    end
    steady_source = 1'b0;
    drain();
  endtask

  // Stimulus
  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= EV_TICK;
    in_ch.key_code <= 8'h00;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= IDX_TIMEOUT;
    cfg_ch.data    <= 8'h00;
    rst_n          <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // default settings: unknown command, play with stray release and letter
    // replacement, each special key fired or cancelled, then a timeout that
    // starts from the tick left over by the first selection
    send_event(EV_TICK, 8'hFF);
    send_event(EV_UNKNOWN, CH_A);
    send_event(EV_PRESS, CH_A);
    send_event(EV_RELEASE, CH_A + 8'd1);
    send_event(EV_RELEASE, CH_A);
    send_event(EV_TICK, 8'h00);
    send_event(EV_PRESS, CH_ZERO);
    send_event(EV_RELEASE, CH_ZERO);
    send_event(EV_PRESS, CH_Z);
    send_event(EV_RELEASE, CH_Z);
    send_event(EV_PRESS, CH_A + 8'd12);
    send_event(EV_RELEASE, CH_A + 8'd12);
    send_event(EV_PRESS, CH_NINE);
    send_event(EV_RELEASE, CH_NINE);
    send_event(EV_PRESS, RST_STOP);
    send_event(EV_TICK, 8'h00);
    send_event(EV_PRESS, RST_VUP);
    send_event(EV_RELEASE, RST_VUP);
    send_event(EV_PRESS, RST_VDN);
    send_event(EV_TICK, 8'h00);
    send_event(EV_PRESS, CH_A);
    send_event(EV_RELEASE, CH_A);
    repeat (4) send_event(EV_TICK, 8'h00);
    drain();

    // extreme settings; a write to an unused index changes nothing
    write_reg(8'hFF, 8'hA5);
    configure(8'h01, 8'h00, 8'hFF, CH_A);
    send_event(EV_PRESS, 8'h00);
    send_event(EV_TICK, 8'h00);
    send_event(EV_PRESS, 8'hFF);
    send_event(EV_RELEASE, 8'hFF);
    send_event(EV_PRESS, CH_A);
    send_event(EV_RELEASE, CH_A);
    send_event(EV_TICK, 8'h00);
    run_phase(PHASE_ITEMS);
    drain();

    // longest timeout, upper data bits set
    configure(8'hFF, pick_code(), pick_code(), pick_code());
    run_phase(PHASE_ITEMS);

    // zero timeout fires only on the wrapped count
    configure(8'h00, pick_code(), pick_code(), pick_code());
    run_phase(PHASE_ITEMS);

    for (int p = 3; p < PHASE_COUNT; p++) begin
      configure({4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))},
                pick_code(), pick_code(), pick_code());
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("keypad_selection_decoder regression: pass");
    end else begin
      $display("keypad_selection_decoder regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("keypad_selection_decoder regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/kpd_pkg.sv
src/kpd_if.sv
src/kpd_cfg.sv
src/kpd_core.sv
src/keypad_selection_decoder.sv
src/kpd_checker.sv
test/keypad_selection_decoder_test.sv
